// ===== rtl/core/iluhn_pkg.sv =====
// ----------------------------------------------------------------------------
// iluhn_pkg
// shared types and constants for the imei luhn checker
// ----------------------------------------------------------------------------
package iluhn_pkg;

   // first imei register
   localparam int unsigned FIRST_IMEI_W = 50;
   localparam logic [FIRST_IMEI_W-1:0] FIRST_IMEI_LIMIT = 50'd999999999999999;

   // digits kept for comparison
   localparam int unsigned MAX_DIGITS = 16;

   // decimal store: enough digits for any expected imei (body * 10 + check)
   localparam int unsigned STORE_DIGITS = 16;
   localparam int unsigned STORE_IDX_W  = $clog2(STORE_DIGITS);

   // packed bcd shift register, four bits per stored digit
   localparam int unsigned BCD_W = 4 * STORE_DIGITS;

   // body digits produced by the increment pass (first imei without its check digit)
   localparam int unsigned BODY_DIGITS = STORE_DIGITS - 1;

   // conversion steps, one per binary bit
   localparam int unsigned CONV_CNT_W = $clog2(FIRST_IMEI_W);

   // position and length counters
   localparam int unsigned POS_W = 5;
   localparam logic [POS_W-1:0] POS_MAX = '1;

   localparam logic [7:0] ASCII_ZERO = 8'h30;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
   } iluhn_req_type;

   typedef struct packed {
      logic       imei_matches;
      logic [3:0] check_digit;
   } iluhn_rsp_type;

   // digit generator status toward the back end
   typedef struct packed {
      logic ready;
      logic busy;
   } iluhn_gen_status_type;

endpackage

// ===== rtl/core/sequential_imei_luhn_checker.sv =====
// ----------------------------------------------------------------------------
// sequential_imei_luhn_checker
// checks a received second imei string against the one derived from the
// provisioned first imei (body plus one, new luhn check digit)
// ----------------------------------------------------------------------------
//
//   port group   dir   handshake              payload
//   req_*        in    req_valid / req_stall  iluhn_req_type (char_code, last_char)
//   rsp_*        out   rsp_valid / rsp_stall  iluhn_rsp_type (imei_matches, check_digit)
//   csr_*        in    csr_write_enable       50-bit first imei
//
// - one character per cycle once the expected digits exist, unless a
//   stalled result register holds back a last_char request; the first character
//   after reset or a csr write waits while the digit generator runs: 50 conversion
//   steps (one per binary bit), 15 increment/luhn steps (one decimal digit each), one finish step
// - reset is synchronous and active high; it clears all control state and
//   the first imei register to zero
// - a two-entry request queue lets the front keep taking requests while the
//   back waits on the generator or on a stalled result register
// - a result appears only for the request carrying last_char
//
module sequential_imei_luhn_checker (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_valid,
   output logic                               req_stall,
   input  iluhn_pkg::iluhn_req_type           req_payload,

   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output iluhn_pkg::iluhn_rsp_type           rsp_payload,

   input  logic                               csr_write_enable,
   input  logic [iluhn_pkg::FIRST_IMEI_W-1:0] csr_write_data
);

   // front to back queue signals
   logic                     q_full;
   logic                     q_head_valid;
   iluhn_pkg::iluhn_req_type q_head_data;
   logic                     q_pop;

   // generator link
   iluhn_pkg::iluhn_gen_status_type   gen_status;
   logic                              gen_start;
   logic [iluhn_pkg::STORE_IDX_W-1:0] gen_rd_index;
   logic [3:0]                        gen_rd_digit;
   logic [iluhn_pkg::POS_W-1:0]       gen_length;
   logic [3:0]                        gen_luhn;

   // front: stall only when the queue is full
   assign req_stall = q_full;

   iluhn_req_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_valid && !q_full),
      .push_data  (req_payload),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (q_head_valid),
      .head_data  (q_head_data)
   );

   // expected digit builder, also owns the first imei register
   iluhn_digit_gen u_digit_gen (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .start            (gen_start),
      .rd_index         (gen_rd_index),
      .rd_digit         (gen_rd_digit),
      .exp_length       (gen_length),
      .luhn_digit       (gen_luhn),
      .status           (gen_status)
   );

   // back: per-character compare and result register
   iluhn_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (q_head_valid),
      .head_data   (q_head_data),
      .pop         (q_pop),
      .gen_status  (gen_status),
      .gen_start   (gen_start),
      .rd_index    (gen_rd_index),
      .rd_digit    (gen_rd_digit),
      .exp_length  (gen_length),
      .luhn_digit  (gen_luhn),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== rtl/core/iluhn_req_queue.sv =====
// ----------------------------------------------------------------------------
// iluhn_req_queue
// two-entry request queue between the front handshake and the back end
// ----------------------------------------------------------------------------
module iluhn_req_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  iluhn_pkg::iluhn_req_type push_data,
   input  logic                   pop,
   output logic                   full,
   output logic                   head_valid,
   output iluhn_pkg::iluhn_req_type head_data
);

   iluhn_pkg::iluhn_req_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/core/iluhn_digit_gen.sv =====
// ----------------------------------------------------------------------------
// iluhn_digit_gen
// holds the first imei and builds the expected second imei digits
// ----------------------------------------------------------------------------
module iluhn_digit_gen (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          csr_write_enable,
   input  logic [iluhn_pkg::FIRST_IMEI_W-1:0]            csr_write_data,
   input  logic                                          start,
   input  logic [iluhn_pkg::STORE_IDX_W-1:0]             rd_index,
   output logic [3:0]                                    rd_digit,
   output logic [iluhn_pkg::POS_W-1:0]                   exp_length,
   output logic [3:0]                                    luhn_digit,
   output iluhn_pkg::iluhn_gen_status_type               status
);

   typedef enum logic [1:0] {
      GEN_IDLE,
      GEN_CONV,
      GEN_INC,
      GEN_FIN
   } gen_state_type;

   gen_state_type state_ff, state_in;
   logic [iluhn_pkg::FIRST_IMEI_W-1:0] first_imei_ff, first_imei_in;
   logic [iluhn_pkg::FIRST_IMEI_W-1:0] bin_ff, bin_in;
   logic [iluhn_pkg::BCD_W-1:0]        bcd_ff, bcd_in;
   logic [iluhn_pkg::CONV_CNT_W-1:0]   step_ff, step_in;
   logic [iluhn_pkg::STORE_IDX_W-1:0]  top_ff, top_in;
   logic                               carry_ff, carry_in;
   logic [3:0]                         sum_ff, sum_in;
   logic                               ready_ff, ready_in;
   logic [iluhn_pkg::POS_W-1:0]        length_ff, length_in;
   logic [3:0]                         luhn_ff, luhn_in;
   logic [3:0]                         store_ff [iluhn_pkg::STORE_DIGITS];

   logic [iluhn_pkg::BCD_W-1:0] bcd_adj;
   logic [4:0]       body_sum;
   logic [3:0]       body_digit;
   logic             body_carry;
   logic [4:0]       dbl_digit;
   logic [4:0]       luhn_sum;
   logic             store_we;
   logic [iluhn_pkg::STORE_IDX_W-1:0] store_idx;
   logic [3:0]       store_val;

   assign rd_digit     = store_ff[rd_index];
   assign exp_length   = length_ff;
   assign luhn_digit   = luhn_ff;
   assign status.ready = ready_ff;
   assign status.busy  = (state_ff != GEN_IDLE);

   // double dabble adjust, each digit on its own
   always_comb begin
      for (int i = 0; i < iluhn_pkg::STORE_DIGITS; i++) begin
         bcd_adj[4*i +: 4] = (bcd_ff[4*i +: 4] >= 4'd5) ?
                             bcd_ff[4*i +: 4] + 4'd3 : bcd_ff[4*i +: 4];
      end
   end

   // one body digit per cycle: increment ripple and luhn accumulate
   always_comb begin
      body_sum   = {1'b0, bcd_ff[7:4]} + {4'd0, carry_ff};
      body_carry = (body_sum >= 5'd10);
      body_digit = body_carry ? 4'd0 : body_sum[3:0];
      dbl_digit  = {1'b0, body_digit};
      if (step_ff[0] == 1'b0) begin
         dbl_digit = {body_digit, 1'b0};
         if (dbl_digit >= 5'd10) begin
            dbl_digit = dbl_digit - 5'd9;
         end
      end
      luhn_sum = {1'b0, sum_ff} + dbl_digit;
      if (luhn_sum >= 5'd10) begin
         luhn_sum = luhn_sum - 5'd10;
      end
   end

   always_comb begin
      state_in      = state_ff;
      first_imei_in = first_imei_ff;
      bin_in        = bin_ff;
      bcd_in        = bcd_ff;
      step_in       = step_ff;
      top_in        = top_ff;
      carry_in      = carry_ff;
      sum_in        = sum_ff;
      ready_in      = ready_ff;
      length_in     = length_ff;
      luhn_in       = luhn_ff;
      store_we      = 1'b0;
      store_idx     = '0;
      store_val     = body_digit;

      case (state_ff)
         GEN_IDLE: begin
            if (start) begin
               state_in = GEN_CONV;
               bin_in   = first_imei_ff;
               bcd_in   = '0;
               step_in  = '0;
            end
         end
         GEN_CONV: begin
            bcd_in  = {bcd_adj[iluhn_pkg::BCD_W-2:0], bin_ff[iluhn_pkg::FIRST_IMEI_W-1]};
            bin_in  = {bin_ff[iluhn_pkg::FIRST_IMEI_W-2:0], 1'b0};
            step_in = step_ff + 1'b1;
            if (step_ff == iluhn_pkg::CONV_CNT_W'(iluhn_pkg::FIRST_IMEI_W - 1)) begin
               state_in = GEN_INC;
               step_in  = '0;
               carry_in = 1'b1;
               sum_in   = 4'd0;
               top_in   = '0;
            end
         end
         GEN_INC: begin
            // least significant bcd digit is the dropped check digit
            bcd_in    = {4'd0, bcd_ff[iluhn_pkg::BCD_W-1:4]};
            carry_in  = body_carry;
            sum_in    = luhn_sum[3:0];
            store_we  = 1'b1;
            store_idx = step_ff[iluhn_pkg::STORE_IDX_W-1:0] + 1'b1;
            if (body_digit != 4'd0) begin
               top_in = step_ff[iluhn_pkg::STORE_IDX_W-1:0];
            end
            step_in = step_ff + 1'b1;
            if (step_ff == iluhn_pkg::CONV_CNT_W'(iluhn_pkg::BODY_DIGITS - 1)) begin
               state_in = GEN_FIN;
            end
         end
         GEN_FIN: begin
            luhn_in   = (sum_ff == 4'd0) ? 4'd0 : 4'd10 - sum_ff;
            store_we  = 1'b1;
            store_idx = '0;
            store_val = luhn_in;
            length_in = iluhn_pkg::POS_W'(top_ff) + iluhn_pkg::POS_W'(2);
            ready_in  = 1'b1;
            state_in  = GEN_IDLE;
         end
         default: begin
            state_in = GEN_IDLE;
         end
      endcase

      if (csr_write_enable) begin
         first_imei_in = (csr_write_data > iluhn_pkg::FIRST_IMEI_LIMIT) ?
                         iluhn_pkg::FIRST_IMEI_LIMIT : csr_write_data;
         ready_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= GEN_IDLE;
         first_imei_ff <= '0;
         ready_ff      <= 1'b0;
         length_ff     <= '0;
         luhn_ff       <= 4'd0;
      end else begin
         state_ff      <= state_in;
         first_imei_ff <= first_imei_in;
         ready_ff      <= ready_in;
         length_ff     <= length_in;
         luhn_ff       <= luhn_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff   <= bin_in;
      bcd_ff   <= bcd_in;
      step_ff  <= step_in;
      top_ff   <= top_in;
      carry_ff <= carry_in;
      sum_ff   <= sum_in;
      if (store_we) begin
         store_ff[store_idx] <= store_val;
      end
   end

endmodule

// ===== rtl/core/iluhn_back.sv =====
// ----------------------------------------------------------------------------
// iluhn_back
// compares queued characters against the expected digits, drives results
// ----------------------------------------------------------------------------
module iluhn_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              head_valid,
   input  iluhn_pkg::iluhn_req_type          head_data,
   output logic                              pop,
   input  iluhn_pkg::iluhn_gen_status_type   gen_status,
   output logic                              gen_start,
   output logic [iluhn_pkg::STORE_IDX_W-1:0] rd_index,
   input  logic [3:0]                        rd_digit,
   input  logic [iluhn_pkg::POS_W-1:0]       exp_length,
   input  logic [3:0]                        luhn_digit,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output iluhn_pkg::iluhn_rsp_type          rsp_payload
);

   logic [iluhn_pkg::POS_W-1:0] pos_ff, pos_in;
   logic                        mis_ff, mis_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   iluhn_pkg::iluhn_rsp_type    rsp_ff, rsp_in;

   logic                        out_free;
   logic                        in_range;
   logic                        char_bad;
   logic                        mis_next;
   logic [iluhn_pkg::POS_W-1:0] pos_next;
   logic [iluhn_pkg::POS_W-1:0] rev_pos;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign gen_start = head_valid && !gen_status.ready && !gen_status.busy;

   // digits are stored least significant first
   assign rev_pos  = exp_length - iluhn_pkg::POS_W'(1) - pos_ff;
   assign rd_index = rev_pos[iluhn_pkg::STORE_IDX_W-1:0];

   always_comb begin
      in_range = (pos_ff < exp_length) &&
                 (pos_ff < iluhn_pkg::POS_W'(iluhn_pkg::MAX_DIGITS));
      char_bad = !in_range || (head_data.char_code != iluhn_pkg::ASCII_ZERO + {4'd0, rd_digit});
      mis_next = mis_ff || char_bad;
      pos_next = (pos_ff == iluhn_pkg::POS_MAX) ? pos_ff : pos_ff + 1'b1;
      pop      = head_valid && gen_status.ready && (!head_data.last_char || out_free);

      pos_in       = pos_ff;
      mis_in       = mis_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;

      if (pop) begin
         if (head_data.last_char) begin
            pos_in                = '0;
            mis_in                = 1'b0;
            rsp_valid_in          = 1'b1;
            rsp_in.imei_matches   = !mis_next && (pos_next == exp_length);
            rsp_in.check_digit    = luhn_digit;
         end else begin
            pos_in = pos_next;
            mis_in = mis_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         mis_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         mis_ff       <= mis_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule

// ===== bench/tb_sequential_imei_luhn_checker.sv =====
// ----------------------------------------------------------------------------
// tb_sequential_imei_luhn_checker
// self-checking bench for the second imei checker: a directed table of
// strings and register writes, then random phases of well-formed, corrupted,
// truncated, over-long and noise strings; directed verdicts are checked against
// the table, random ones against a behavioral model of the checker kept in the bench
// ----------------------------------------------------------------------------
module tb_sequential_imei_luhn_checker;

   localparam int IDLE_LIMIT    = 3000;  // cycles with no handshake before giving up
   localparam int SETTLE_CYCLES = 100;   // time for a full digit generator run
   localparam int RANDOM_ITEMS  = 500;
   localparam int LONG_HOLD     = 400;

   // one row of the directed part: either a register write or a string
   typedef struct {
      bit                                 csr;
      logic [iluhn_pkg::FIRST_IMEI_W-1:0] csr_value;
      string                              text;
      bit                                 ends;        // last_char on the final character
      bit                                 typed;       // verdict written into the row
      bit                                 want_match;
      logic [3:0]                         want_check;
   } stim_row_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_stall;
   iluhn_pkg::iluhn_req_type           req_payload = '0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   iluhn_pkg::iluhn_rsp_type           rsp_payload;
   logic                               csr_write_enable = 1'b0;
   logic [iluhn_pkg::FIRST_IMEI_W-1:0] csr_write_data = '0;

   always #1 clock = ~clock;

   sequential_imei_luhn_checker DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // ---------------------------------------------------------------------------
   // behavioral model of the checker
   // ---------------------------------------------------------------------------
   logic [iluhn_pkg::FIRST_IMEI_W-1:0] imei_reg = '0;      // saturated first imei
   string                   second_text;        // expected second imei, ascii
   logic [3:0]              check_reg = '0;
   bit                      digits_valid = 1'b0;
   int unsigned             char_pos = 0;
   bit                      saw_mismatch = 1'b0;

   iluhn_pkg::iluhn_rsp_type pending_verdicts[$];   // verdicts not yet seen on rsp_*
   iluhn_pkg::iluhn_rsp_type want;
   int            fail_count = 0;
   int            items_sent = 0;
   int            quiet_cycles = 0;
   bit            sender_idles = 1'b0;
   bit            receiver_idles = 1'b0;
   int            hold_request = 0;

   // every second digit from the right doubled, digit sums added
   function automatic logic [3:0] luhn_mod10(input longint unsigned v);
      int unsigned sum;
      int unsigned d;
      bit          dbl;
      sum = 0;
      dbl = 1'b1;
      while (v != 0) begin
         d = 32'(v % 64'd10);
         if (dbl) begin
            d = d * 2;
            d = d % 10 + d / 10;
         end
         sum += d;
         dbl = !dbl;
         v /= 10;
      end
      return 4'((10 - sum % 10) % 10);
   endfunction

   // drop the check digit, add one, append the new check digit
   function automatic string derive_second_text(
         input logic [iluhn_pkg::FIRST_IMEI_W-1:0] first, output logic [3:0] check);
      longint unsigned body;
      body = 64'(first);
      body = body / 10 + 1;
      check = luhn_mod10(body);
      return $sformatf("%0d", body * 10 + check);
   endfunction

   function automatic void load_first_imei(input logic [iluhn_pkg::FIRST_IMEI_W-1:0] v);
      logic [iluhn_pkg::FIRST_IMEI_W-1:0] sat;
      sat = (v > iluhn_pkg::FIRST_IMEI_LIMIT) ? iluhn_pkg::FIRST_IMEI_LIMIT : v;
      imei_reg = sat;
      digits_valid = 1'b0;   // a string in progress goes on against the new digits
   endfunction

   // returns 1 when the request carries a verdict
   function automatic bit predict_verdict(input logic [7:0] ch, input bit last,
                                          output iluhn_pkg::iluhn_rsp_type verdict);
      verdict = '0;
      if (!digits_valid) begin
         second_text = derive_second_text(imei_reg, check_reg);
         digits_valid = 1'b1;
      end
      if (char_pos < second_text.len() && char_pos < iluhn_pkg::MAX_DIGITS) begin
         if (ch != second_text[char_pos])
            saw_mismatch = 1'b1;
      end else begin
         saw_mismatch = 1'b1;   // excess character
      end
      if (char_pos < iluhn_pkg::POS_MAX)
         char_pos++;
      if (!last)
         return 1'b0;
      verdict.imei_matches = !saw_mismatch && char_pos == second_text.len();
      verdict.check_digit  = check_reg;
      char_pos = 0;
      saw_mismatch = 1'b0;
      return 1'b1;
   endfunction

   // random register value: in range, at the limit, above it, tiny
   function automatic logic [iluhn_pkg::FIRST_IMEI_W-1:0] pick_first_imei();
      logic [63:0] r;
      r = {$urandom, $urandom};
      case ($urandom_range(0, 6))
         0: return '0;
         1: return iluhn_pkg::FIRST_IMEI_LIMIT;
         2: return iluhn_pkg::FIRST_IMEI_LIMIT +
                   iluhn_pkg::FIRST_IMEI_W'($urandom_range(1, 1000));
         3: return '1;
         4: return r[iluhn_pkg::FIRST_IMEI_W-1:0];
         5: return iluhn_pkg::FIRST_IMEI_W'(r % (64'(iluhn_pkg::FIRST_IMEI_LIMIT) + 64'd1));
         default: return iluhn_pkg::FIRST_IMEI_W'($urandom_range(0, 99999));
      endcase
   endfunction

   // ---------------------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------------------
   // valid drops only on a gap, so a back-to-back request never sees valid
   // lowered and raised in the same step
   task automatic send_request(input logic [7:0] ch, input bit last, input bit typed,
                               input bit typed_match, input logic [3:0] typed_check);
      int                       gap;
      iluhn_pkg::iluhn_rsp_type verdict;
      gap = sender_idles ? $urandom_range(0, 14) : 0;
      if (gap != 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_payload <= '{char_code: ch, last_char: last};
      do @(posedge clock); while (req_stall);
      items_sent++;
      if (predict_verdict(ch, last, verdict)) begin
         if (typed) begin
            verdict.imei_matches = typed_match;
            verdict.check_digit  = typed_check;
         end
         pending_verdicts.push_back(verdict);
      end
   endtask

   task automatic send_text(input string s, input bit ends);
      for (int i = 0; i < s.len(); i++)
         send_request(s[i], ends && i == s.len() - 1, 1'b0, 1'b0, 4'd0);
   endtask

   task automatic send_noise(input int count);
      for (int i = 0; i < count; i++)
         send_request(8'($urandom_range(0, 255)), i == count - 1, 1'b0, 1'b0, 4'd0);
   endtask

   task automatic sender_pause();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_verdicts.size() != 0) @(posedge clock);
   endtask

   // register writes only with the block idle: all verdicts in, then enough
   // cycles for a request without a verdict to finish in the generator
   task automatic write_first_imei(input logic [iluhn_pkg::FIRST_IMEI_W-1:0] v);
      sender_pause();
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      load_first_imei(v);
   endtask

   // ---------------------------------------------------------------------------
   // result side: random stall before each result, one long hold on request
   // ---------------------------------------------------------------------------
   initial begin
      int g;
      forever begin
         g = receiver_idles ? $urandom_range(0, 14) : 0;
         if (hold_request != 0) begin
            g = hold_request;
            hold_request = 0;
         end
         if (g != 0) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
            repeat (g - 1) @(negedge clock);
            @(negedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   // compare every accepted result with the oldest pending verdict
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_verdicts.size() == 0) begin
            $display("%0t: result with none pending, expected none, actual %p",
                     $time, rsp_payload);
            fail_count++;
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_payload.imei_matches !== want.imei_matches) begin
               $display("%0t: imei_matches expected %0b actual %0b",
                        $time, want.imei_matches, rsp_payload.imei_matches);
               fail_count++;
            end
            if (rsp_payload.check_digit !== want.check_digit) begin
               $display("%0t: check_digit expected %0d actual %0d",
                        $time, want.check_digit, rsp_payload.check_digit);
               fail_count++;
            end
         end
      end
   end

   // watchdog: too long without any handshake means the block hung
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------------
   stim_row_type directed_rows[9];

   initial begin
      string      exp_text;
      string      s;
      int         k;
      int         len;
      int         directed_count;
      int         phase;
      logic [3:0] unused_check;
      bit         last;

      // after reset the register is zero: body 1, check 8, second imei "18";
      // at the limit the body is 1 followed by 14 zeros, check 8 again
      directed_rows = '{
         '{1'b0, '0, "18", 1'b1, 1'b1, 1'b1, 4'd8},               // exact match
         '{1'b0, '0, "\377", 1'b1, 1'b1, 1'b0, 4'd8},             // top byte
         '{1'b0, '0, "188", 1'b1, 1'b1, 1'b0, 4'd8},              // one char too many
         '{1'b0, '0, "1", 1'b1, 1'b1, 1'b0, 4'd8},                // too short
         '{1'b0, '0, "1", 1'b0, 1'b0, 1'b0, 4'd0},                // string left open
         '{1'b1, iluhn_pkg::FIRST_IMEI_LIMIT, "", 1'b0, 1'b0, 1'b0, 4'd0},  // write mid-string
         '{1'b0, '0, "000000000000008", 1'b1, 1'b1, 1'b1, 4'd8},  // rest of new imei
         '{1'b1, '1, "", 1'b0, 1'b0, 1'b0, 4'd0},                 // saturates to limit
         '{1'b0, '0, "9", 1'b1, 1'b1, 1'b0, 4'd8}
      };

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // directed part, no idling
      foreach (directed_rows[r]) begin
         if (directed_rows[r].csr) begin
            write_first_imei(directed_rows[r].csr_value);
         end else begin
            len = directed_rows[r].text.len();
            for (int i = 0; i < len; i++) begin
               last = directed_rows[r].ends && i == len - 1;
               send_request(directed_rows[r].text[i], last, directed_rows[r].typed && last,
                            directed_rows[r].want_match, directed_rows[r].want_check);
            end
         end
      end
      directed_count = items_sent;

      // random phases: new register value, then a few strings
      phase = 0;
      while (items_sent < directed_count + RANDOM_ITEMS) begin
         sender_idles   = $urandom_range(0, 3) != 0;
         receiver_idles = $urandom_range(0, 3) != 0;
         write_first_imei(pick_first_imei());
         if (phase == 1) begin
            // receiver holds off while one-character requests keep coming,
            // so the request queue fills and the input stalls
            hold_request = LONG_HOLD;
            sender_idles = 1'b0;
            send_noise(1);
            repeat (23) send_noise(1);
         end else begin
            repeat ($urandom_range(1, 4)) begin
               exp_text = derive_second_text(imei_reg, unused_check);
               len = exp_text.len();
               case ($urandom_range(0, 9))
                  5: begin   // one character corrupted
                     s = exp_text;
                     s.putc($urandom_range(0, len - 1), byte'($urandom_range(1, 255)));
                     send_text(s, 1'b1);
                  end
                  6: send_text(exp_text.substr(0, $urandom_range(0, len - 2)), 1'b1);
                  7: begin   // trailing excess, may run past position saturation
                     send_text(exp_text, 1'b0);
                     send_noise($urandom_range(1, 20));
                  end
                  8: send_noise($urandom_range(1, 40));
                  9: begin   // register write in the middle of a string
                     k = $urandom_range(1, len - 1);
                     send_text(exp_text.substr(0, k - 1), 1'b0);
                     write_first_imei(pick_first_imei());
                     exp_text = derive_second_text(imei_reg, unused_check);
                     if (k < exp_text.len())
                        send_text(exp_text.substr(k, exp_text.len() - 1), 1'b1);
                     else
                        send_noise(1);
                  end
                  default: send_text(exp_text, 1'b1);
               endcase
            end
         end
         phase++;
      end

      // drain, then allow the pipeline to settle
      sender_pause();
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_verdicts.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
